// File: rtl/core/utd_pkg.sv
// Package: item types, queue entry type and lead-byte decoding shared by the decoder modules.
package utd_pkg;

  // One input item: a raw byte of the UTF-8 string and its end-of-string mark.
  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  // One result item: a UTF-16 code unit or the closing terminator.
  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_terminator;
  } out_item_t;

  // Work handed from the front to the back: an optional character and an optional terminator.
  typedef struct packed {
    logic        emit;
    logic [15:0] unit;
    logic        last;
  } utd_entry_t;

  // Outcome of decoding a byte as a lead byte.
  typedef struct packed {
    logic        single;
    logic [15:0] value;
    logic [2:0]  remaining;
  } lead_info_t;

  localparam logic [1:0] CONT_TAG  = 2'b10;
  localparam logic [7:0] MASK_CONT = 8'h3f;

  // Classify a lead byte and extract its payload bits.
  function automatic lead_info_t decode_lead(input logic [7:0] b);
    lead_info_t info;
    info = '0;
    unique casez (b)
      8'b0???_????: begin
        info.single = 1'b1;
        info.value  = {8'h00, b};
      end
      8'b110?_????: begin
        info.value     = {11'h000, b[4:0]};
        info.remaining = 3'd1;
      end
      8'b1110_????: begin
        info.value     = {12'h000, b[3:0]};
        info.remaining = 3'd2;
      end
      8'b1111_0???: begin
        info.value     = {13'h0000, b[2:0]};
        info.remaining = 3'd3;
      end
      8'b1111_10??: begin
        info.value     = {14'h0000, b[1:0]};
        info.remaining = 3'd4;
      end
      8'b1111_110?: begin
        info.value     = {15'h0000, b[0]};
        info.remaining = 3'd5;
      end
      default: begin
        info = '0;
      end
    endcase
    return info;
  endfunction

endpackage

// File: rtl/core/utd_front.sv
// Front end: accepts bytes, tracks the pending sequence and queues the work each byte causes.
module utd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  utd_pkg::in_item_t  in_item,
  input  logic               queue_full,
  output logic               in_stall,
  output logic               push,
  output utd_pkg::utd_entry_t push_entry
);
  import utd_pkg::*;

  logic [15:0] partial_value;
  logic [15:0] partial_value_next;
  logic [2:0]  bytes_remaining;
  logic [2:0]  bytes_remaining_next;
  logic        accept;
  logic        is_cont;
  logic [15:0] acc;
  logic [2:0]  rem_dec;
  lead_info_t  lead;
  logic        emit;
  logic [15:0] unit;

  assign in_stall = queue_full;
  assign accept   = in_valid && !queue_full;
  assign is_cont  = (in_item.byte_value[7:6] == CONT_TAG);
  assign acc      = {partial_value[9:0], in_item.byte_value[5:0] & MASK_CONT[5:0]};
  assign rem_dec  = bytes_remaining - 3'd1;
  assign lead     = decode_lead(in_item.byte_value);

  always_comb begin
    emit                 = 1'b0;
    unit                 = '0;
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    if ((bytes_remaining != 3'd0) && is_cont) begin
      bytes_remaining_next = rem_dec;
      if (rem_dec == 3'd0) begin
        emit               = 1'b1;
        unit               = acc;
        partial_value_next = '0;
      end else begin
        partial_value_next = acc;
      end
    end else begin
      // A new lead, including the case where a broken sequence is abandoned.
      emit                 = lead.single;
      unit                 = lead.value;
      partial_value_next   = lead.single ? 16'h0000 : lead.value;
      bytes_remaining_next = lead.remaining;
    end
    if (in_item.last_byte) begin
      partial_value_next   = '0;
      bytes_remaining_next = '0;
    end
  end

  assign push            = accept && (emit || in_item.last_byte);
  assign push_entry.emit = emit;
  assign push_entry.unit = unit;
  assign push_entry.last = in_item.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= '0;
    end else if (accept) begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
    end
  end

endmodule

// File: rtl/core/utd_queue.sv
// Short first-in first-out queue of work entries between the front and the back.
module utd_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  utd_pkg::utd_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output utd_pkg::utd_entry_t head
);
  import utd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  utd_entry_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full      = (count == CNT_W'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// File: rtl/core/utd_back.sv
// Back end: turns queued work into result items through a registered output stage.
module utd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                not_empty,
  input  utd_pkg::utd_entry_t head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output utd_pkg::out_item_t  out_item
);
  import utd_pkg::*;

  logic can_load;
  logic term_phase;
  logic send_unit;

  assign can_load  = !out_valid || !out_stall;
  // The character goes out first; the terminator of the same entry follows.
  assign send_unit = head.emit && !term_phase;
  assign pop       = can_load && not_empty && !(send_unit && head.last);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      term_phase <= 1'b0;
    end else if (can_load) begin
      out_valid <= not_empty;
      if (not_empty) begin
        term_phase <= send_unit && head.last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && not_empty) begin
      out_item.code_unit     <= send_unit ? head.unit : 16'h0000;
      out_item.is_terminator <= !send_unit;
    end
  end

endmodule

// File: rtl/core/utf8_to_utf16_decoder_core.sv
// Top level: streaming UTF-8 to UTF-16 decoder built from a front end, a queue and a back end.
// The decoder takes one UTF-8 byte per item and gives one 16-bit code unit for each completed
// character, keeping only the low 16 bits of forms up to six bytes long. Invalid lead bytes are
// dropped silently; a byte that breaks a pending sequence abandons it and is decoded afresh as a
// lead. After the byte marked last, any pending sequence is discarded and a zero item with
// is_terminator set closes the string. A byte is accepted every cycle while the queue has room;
// the output stage delivers one result item per cycle while out_stall is low, so a byte that
// both completes a character and ends the string gives two result items, and the QUEUE_DEPTH
// entries between the front and the back absorb such bursts and stalls from the receiving side.
// An accepted byte passes through the queue and then the registered output stage.
module utf8_to_utf16_decoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  utd_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output utd_pkg::out_item_t out_item
);
  import utd_pkg::*;

  // Handshake between the front end and the queue.
  logic       push;
  utd_entry_t push_entry;
  logic       queue_full;

  // Handshake between the queue and the back end.
  logic       pop;
  logic       not_empty;
  utd_entry_t head;

  // The front end owns the decoding state and stalls only when the queue is full.
  utd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .queue_full (queue_full),
    .in_stall   (in_stall),
    .push       (push),
    .push_entry (push_entry)
  );

  utd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .not_empty  (not_empty),
    .head       (head)
  );

  // The back end drains entries, splitting a character-plus-terminator entry into two items.
  utd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .not_empty (not_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

// File: tb/testbench.sv
// Testbench for the UTF-8 to UTF-16 decoder core: directed and random byte strings, checked item by item.
`timescale 1ns / 100ps

class code_unit_tracker;
  logic [15:0]        acc_bits;
  logic [2:0]         conts_left;
  utd_pkg::out_item_t expected_units[$];
  int                 errors;
  int                 bytes_taken;
  int                 units_checked;
  int                 terminators_checked;

  function new();
    acc_bits            = '0;
    conts_left          = '0;
    errors              = 0;
    bytes_taken         = 0;
    units_checked       = 0;
    terminators_checked = 0;
  endfunction

  // Advance the decoding state by one accepted byte and queue the items it must produce.
  function void note_byte(utd_pkg::in_item_t it);
    logic [7:0]         b;
    utd_pkg::out_item_t unit_item;
    b         = it.byte_value;
    unit_item = '0;
    if (conts_left != 3'd0 && b[7:6] == utd_pkg::CONT_TAG) begin
      acc_bits   = {acc_bits[9:0], b[5:0]};
      conts_left = conts_left - 3'd1;
      if (conts_left == 3'd0) begin
        unit_item.code_unit = acc_bits;
        expected_units.push_back(unit_item);
        acc_bits = '0;
      end
    end else begin
      // Anything else is a lead byte; a sequence it interrupts is simply abandoned.
      acc_bits   = '0;
      conts_left = '0;
      casez (b)
        8'b0???_????: begin
          unit_item.code_unit = {8'h00, b};
          expected_units.push_back(unit_item);
        end
        8'b110?_????: begin
          acc_bits   = {11'h000, b[4:0]};
          conts_left = 3'd1;
        end
        8'b1110_????: begin
          acc_bits   = {12'h000, b[3:0]};
          conts_left = 3'd2;
        end
        8'b1111_0???: begin
          acc_bits   = {13'h0000, b[2:0]};
          conts_left = 3'd3;
        end
        8'b1111_10??: begin
          acc_bits   = {14'h0000, b[1:0]};
          conts_left = 3'd4;
        end
        8'b1111_110?: begin
          acc_bits   = {15'h0000, b[0]};
          conts_left = 3'd5;
        end
        default: begin
          acc_bits = '0;
        end
      endcase
    end
    if (it.last_byte) begin
      acc_bits                = '0;
      conts_left              = '0;
      unit_item.code_unit     = '0;
      unit_item.is_terminator = 1'b1;
      expected_units.push_back(unit_item);
    end
    bytes_taken++;
  endfunction

  // Compare one delivered item with the oldest outstanding one.
  function void check_unit(utd_pkg::out_item_t got);
    utd_pkg::out_item_t want;
    if (expected_units.size() == 0) begin
      $error("unexpected result item: code_unit %h is_terminator %b",
             got.code_unit, got.is_terminator);
      errors++;
    end else begin
      want = expected_units.pop_front();
      if (got.code_unit !== want.code_unit) begin
        $error("code_unit: expected %h, actual %h", want.code_unit, got.code_unit);
        errors++;
      end
      if (got.is_terminator !== want.is_terminator) begin
        $error("is_terminator: expected %b, actual %b", want.is_terminator, got.is_terminator);
        errors++;
      end
      if (want.is_terminator) begin
        terminators_checked++;
      end else begin
        units_checked++;
      end
    end
  endfunction
endclass

module testbench;

  // Length of the deliberate output hold, long enough to fill the internal queue many times.
  localparam int HOLD_CYCLES  = 60;
  // Roughly how many random bytes each of the three random phases sends.
  localparam int PHASE_BYTES  = 508;
  // Bound on the wait for outstanding results once the input side has finished.
  localparam int DRAIN_LIMIT  = 5000;
  // Extra cycles after the last result, to catch anything the block still emits.
  localparam int SETTLE_CYCLES = 8;

  logic               clk = 1'b0;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  utd_pkg::in_item_t  in_item;
  logic               out_valid;
  logic               out_stall;
  utd_pkg::out_item_t out_item;

  // Bytes waiting to be offered to the block, in order.
  utd_pkg::in_item_t stim_q[$];

  // Idling rates in percent; the sender reads the first, the output side the second.
  int send_gap_pct   = 0;
  int recv_stall_pct = 0;
  // Raised once by the main sequence to ask the output side for one long hold.
  logic squeeze_pending = 1'b0;

  code_unit_tracker units_sb = new();

  utf8_to_utf16_decoder_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always #1 clk = ~clk;

  // Both monitors sample at the rising edge, before any of this edge's updates land, so an
  // item counts exactly when valid was high and stall low going into the edge.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      units_sb.note_byte(in_item);
    end
    if (!rst && out_valid && !out_stall) begin
      units_sb.check_unit(out_item);
    end
  end

  // Output side: random stalls at the current rate, and on request a long hold that is
  // counted here so that the sender keeps offering bytes until the block pushes back.
  initial begin : output_side
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (squeeze_pending) begin
        squeeze_pending = 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          out_stall <= 1'b1;
          @(posedge clk);
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic last);
    utd_pkg::in_item_t it;
    it.byte_value = b;
    it.last_byte  = last;
    stim_q.push_back(it);
  endtask

  // Queue one string of random characters. Most characters are well formed; a few are preceded
  // by a stray byte, cut short, or have a continuation byte replaced by noise. Now and then the
  // string ends in the middle of a character, which the end mark must throw away.
  task automatic queue_random_string();
    int         n_chars;
    int         form;
    int         keep;
    int         bad_pos;
    int         r;
    logic [7:0] lead;
    logic [7:0] stray;
    n_chars = $urandom_range(1, 12);
    for (int c = 0; c < n_chars; c++) begin
      r    = $urandom_range(99);
      form = (r < 35) ? 1 : (r < 55) ? 2 : (r < 72) ? 3 : (r < 84) ? 4 : (r < 92) ? 5 : 6;
      lead = 8'($urandom);
      case (form)
        1: lead[7]   = 1'b0;
        2: lead[7:5] = 3'b110;
        3: lead[7:4] = 4'b1110;
        4: lead[7:3] = 5'b11110;
        5: lead[7:2] = 6'b111110;
        default: lead[7:1] = 7'b1111110;
      endcase
      keep    = form - 1;
      bad_pos = -1;
      if ($urandom_range(99) < 8) begin
        case ($urandom_range(3))
          0: begin
            // A byte that can never start a character.
            stray = $urandom_range(1) ? {utd_pkg::CONT_TAG, 6'($urandom)}
                                      : {7'b1111111, 1'($urandom)};
            queue_byte(stray, 1'b0);
          end
          1: keep = (form > 1) ? $urandom_range(form - 2) : 0;
          2: bad_pos = (form > 1) ? $urandom_range(1, form - 1) : -1;
          default: queue_byte(8'($urandom), 1'b0);
        endcase
      end
      queue_byte(lead, 1'b0);
      for (int k = 1; k <= keep; k++) begin
        if (k == bad_pos) begin
          queue_byte(8'($urandom), 1'b0);
        end else begin
          queue_byte({utd_pkg::CONT_TAG, 6'($urandom)}, 1'b0);
        end
      end
    end
    if ($urandom_range(99) < 10) begin
      queue_byte({2'b11, 6'($urandom)}, 1'b0);
      if ($urandom_range(1)) begin
        queue_byte({utd_pkg::CONT_TAG, 6'($urandom)}, 1'b0);
      end
    end
    stim_q[stim_q.size() - 1].last_byte = 1'b1;
  endtask

  // Offer every queued byte in turn, with random gaps at the current rate. A byte stays on
  // the port unchanged until the edge at which the block accepts it.
  task automatic send_queued_bytes();
    utd_pkg::in_item_t it;
    while (stim_q.size() != 0) begin
      it = stim_q.pop_front();
      while ($urandom_range(99) < send_gap_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      in_valid <= 1'b1;
      in_item  <= it;
      @(posedge clk);
      while (in_stall) begin
        @(posedge clk);
      end
    end
  endtask

  task automatic run_random_phase(input int gap_pct, input int stall_pct);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
    while (stim_q.size() < PHASE_BYTES) begin
      queue_random_string();
    end
    send_queued_bytes();
  endtask

  initial begin : main_sequence
    int drain;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed string: a zero byte, a character of every lead class (the five-byte one with
    // distinct continuation bytes so the shift order shows, the others with their largest
    // payload), two bytes that cannot start a character, and a two-byte lead broken by a
    // plain ASCII byte that also ends the string, so one byte yields a character and the
    // terminator together.
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hdf, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hef, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hbf, 1'b0);
    queue_byte(8'hf7, 1'b0);
    repeat (3) queue_byte(8'hbf, 1'b0);
    queue_byte(8'hf8, 1'b0);
    queue_byte(8'h81, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'h83, 1'b0);
    queue_byte(8'h84, 1'b0);
    queue_byte(8'hfd, 1'b0);
    repeat (5) queue_byte(8'hbf, 1'b0);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'hfe, 1'b0);
    queue_byte(8'hc3, 1'b0);
    queue_byte(8'h7f, 1'b1);
    send_queued_bytes();

    // Sender mostly busy against a sluggish receiver, then the reverse, then flat out with
    // one long output hold so that the queue fills and the input side is stalled.
    run_random_phase(30, 74);
    run_random_phase(74, 30);
    squeeze_pending = 1'b1;
    run_random_phase(0, 0);
    in_valid <= 1'b0;

    drain = 0;
    while (units_sb.expected_units.size() != 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (units_sb.expected_units.size() != 0) begin
      $error("%0d expected result items never arrived", units_sb.expected_units.size());
      units_sb.errors++;
    end

    $display("Fed %0d bytes through directed, idling and back-pressure phases;",
             units_sb.bytes_taken);
    $display("matched %0d code units and %0d string terminators, %0d mismatches.",
             units_sb.units_checked, units_sb.terminators_checked, units_sb.errors);
    if (units_sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Backstop in case the handshake locks up.
  initial begin : watchdog
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/utd_pkg.sv
rtl/core/utd_front.sv
rtl/core/utd_queue.sv
rtl/core/utd_back.sv
rtl/core/utf8_to_utf16_decoder_core.sv
tb/testbench.sv
